[rtl/core/hepc_pkg.sv]
// hepc_pkg: shared types and constants of the hci event packet checker
// depends on nothing; imported by the parser, the top level and the checker
package hepc_pkg;

    // packet size limit default, overridable on the top level
    localparam int unsigned MAX_PACKET_BYTES_DEF = 260;

    // h4 lead byte and event codes
    localparam logic [7:0] LEAD_EVENT        = 8'h04;
    localparam logic [7:0] CODE_CMD_COMPLETE = 8'h0e;
    localparam logic [7:0] CODE_LE_META      = 8'h3e;
    localparam logic [7:0] SUB_ADV_REPORT    = 8'h02;

    // advertising report layout: data length sits 8 bytes into a report,
    // a report spans 10 header bytes plus its data
    localparam int unsigned REPORT_START_INIT = 5;
    localparam int unsigned REPORT_LEN_OFFSET = 8;
    localparam int unsigned REPORT_HDR_BYTES  = 10;

    // reports field saturates at its 5-bit maximum
    localparam logic [4:0] REPORTS_SAT = 5'd31;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_AWAITED_OPCODE = '0;

    // result classification
    typedef enum logic [2:0] {
        KIND_OTHER     = 3'd0,
        KIND_CMD_DONE  = 3'd1,
        KIND_ADV       = 3'd2,
        KIND_MALFORMED = 3'd3,
        KIND_DROPPED   = 3'd4
    } t_event_kind;

    // one input transfer
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
        logic       scan_disabled;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        t_event_kind event_kind;
        logic        completion_match;
        logic [7:0]  command_status;
        logic [4:0]  reports_in_packet;
        logic [31:0] report_total;
        logic [31:0] report_disabled_total;
        logic [31:0] malformed_total;
        logic [31:0] failure_total;
        logic [31:0] dropped_total;
    } t_out_item;

    // packet view after the current byte, from parser to classifier
    typedef struct packed {
        logic        oversize;
        logic        too_short;
        logic        length_ok;
        logic        at_least_7;
        logic        at_least_5;
        logic        lead_ok;
        logic [7:0]  evt_code;
        logic [7:0]  subevent;
        logic [15:0] completed_opcode;
        logic [7:0]  status;
        logic [7:0]  num_reports;
        logic [7:0]  reports_done;
    } t_pkt_info;

endpackage

[rtl/core/hepc_stream_if.sv]
// hepc_stream_if: valid/ready channel carrying one payload per transfer
// payload type set at instantiation, usually a struct from hepc_pkg
interface hepc_stream_if #(parameter type t_data = logic) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/hepc_parser.sv]
// hepc_parser: per-packet byte tracking and advertising report walk
// depends on hepc_pkg; gives the packet view including the current byte
module hepc_parser #(
    parameter int unsigned MAX_PACKET_BYTES = hepc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_packet_byte,
    input  logic                i_last_byte,
    output hepc_pkg::t_pkt_info o_info
);
    import hepc_pkg::*;

    localparam int unsigned POS_W   = $clog2(MAX_PACKET_BYTES + 2);
    localparam int unsigned START_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned END_W   = $clog2(MAX_PACKET_BYTES + REPORT_HDR_BYTES + 256);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_lead_ok, n_lead_ok;
    logic [7:0]         r_evt_code, n_evt_code;
    logic [7:0]         r_param_length, n_param_length;
    logic [7:0]         r_subevent, n_subevent;
    logic [15:0]        r_completed_opcode, n_completed_opcode;
    logic [7:0]         r_status, n_status;
    logic [7:0]         r_num_reports, n_num_reports;
    logic [START_W-1:0] r_report_start, n_report_start;
    logic [END_W-1:0]   r_report_end, n_report_end;
    logic [7:0]         r_reports_done, n_reports_done;
    logic               w_take;

    // header capture and report walk for the current byte
    always_comb begin
        n_lead_ok          = r_lead_ok;
        n_evt_code         = r_evt_code;
        n_param_length     = r_param_length;
        n_subevent         = r_subevent;
        n_completed_opcode = r_completed_opcode;
        n_status           = r_status;
        n_num_reports      = r_num_reports;
        n_report_start     = r_report_start;
        n_report_end       = r_report_end;
        n_reports_done     = r_reports_done;
        w_take             = r_pos < POS_W'(MAX_PACKET_BYTES);

        if (w_take) begin
            case (r_pos)
                POS_W'(0): n_lead_ok = (i_packet_byte == LEAD_EVENT);
                POS_W'(1): n_evt_code = i_packet_byte;
                POS_W'(2): n_param_length = i_packet_byte;
                POS_W'(3): n_subevent = i_packet_byte;
                POS_W'(4): begin
                    n_completed_opcode = {8'd0, i_packet_byte};
                    n_num_reports      = i_packet_byte;
                end
                POS_W'(5): n_completed_opcode[15:8] = i_packet_byte;
                POS_W'(6): n_status = i_packet_byte;
                default: ;
            endcase
        end

        // end of a report is known once its data length byte arrives
        if (w_take && r_pos >= POS_W'(5) && r_reports_done < n_num_reports) begin
            if (r_report_end == '0 &&
                END_W'(r_pos) == END_W'(r_report_start) + END_W'(REPORT_LEN_OFFSET)) begin
                n_report_end = END_W'(r_report_start) + END_W'(REPORT_HDR_BYTES)
                             + END_W'(i_packet_byte);
            end else if (r_report_end != '0 && END_W'(r_pos) + END_W'(1) == r_report_end) begin
                n_reports_done = r_reports_done + 8'd1;
                n_report_start = r_report_end[START_W-1:0];
                n_report_end   = '0;
            end
        end

        // position saturates one past the limit
        n_pos = (r_pos > POS_W'(MAX_PACKET_BYTES)) ? r_pos : r_pos + POS_W'(1);
    end

    // packet view, length checks written on the position before increment
    always_comb begin
        o_info.oversize         = r_pos >= POS_W'(MAX_PACKET_BYTES);
        o_info.too_short        = r_pos < POS_W'(2);
        o_info.length_ok        = r_pos == POS_W'(n_param_length) + POS_W'(2);
        o_info.at_least_7       = r_pos >= POS_W'(6);
        o_info.at_least_5       = r_pos >= POS_W'(4);
        o_info.lead_ok          = n_lead_ok;
        o_info.evt_code         = n_evt_code;
        o_info.subevent         = n_subevent;
        o_info.completed_opcode = n_completed_opcode;
        o_info.status           = n_status;
        o_info.num_reports      = n_num_reports;
        o_info.reports_done     = n_reports_done;
    end

    // packet state, cleared at reset and after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last_byte)) begin
            r_pos              <= '0;
            r_lead_ok          <= 1'b0;
            r_evt_code         <= '0;
            r_param_length     <= '0;
            r_subevent         <= '0;
            r_completed_opcode <= '0;
            r_status           <= '0;
            r_num_reports      <= '0;
            r_report_start     <= START_W'(REPORT_START_INIT);
            r_report_end       <= '0;
            r_reports_done     <= '0;
        end else if (i_advance) begin
            r_pos              <= n_pos;
            r_lead_ok          <= n_lead_ok;
            r_evt_code         <= n_evt_code;
            r_param_length     <= n_param_length;
            r_subevent         <= n_subevent;
            r_completed_opcode <= n_completed_opcode;
            r_status           <= n_status;
            r_num_reports      <= n_num_reports;
            r_report_start     <= n_report_start;
            r_report_end       <= n_report_end;
            r_reports_done     <= n_reports_done;
        end
    end

endmodule

[rtl/core/hci_event_packet_checker.sv]
// hci_event_packet_checker: h4 event packet classifier with running totals
// depends on hepc_pkg, hepc_stream_if and hepc_parser
//
// usage
//   i_byte carries one packet byte per transfer with a last-byte mark and
//   the scan-disabled flag; o_event carries one classification per packet,
//   given after the transfer of its last byte, together with the five
//   wrapping 32-bit totals as they stand after that packet
//   the awaited opcode is written over the apb port at byte address 0
//   and must only change while no packet is in flight
// timing
//   a byte is taken in every cycle unless a closing byte waits in the input
//   register for a stalled result; each byte passes that register, is parsed
//   by the byte-offset logic and, if it closes a packet, lands in the result
//   register behind o_event.valid; throughput one byte per clock unless stalled
// reset and stall
//   synchronous active-low reset clears packet state, totals and the
//   awaited opcode; no result is pending afterwards
//   while o_event is stalled the result holds; bytes keep flowing until a
//   second last byte reaches the input register, which then waits
module hci_event_packet_checker #(
    parameter int unsigned MAX_PACKET_BYTES = hepc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hepc_stream_if.sink                       i_byte,
    hepc_stream_if.source                     o_event,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hepc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hepc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hepc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import hepc_pkg::*;

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        w_s1_fire;
    logic        w_emit;
    t_pkt_info   w_info;

    logic [15:0] r_awaited_opcode;
    logic        w_reg_hit;

    logic        r_out_valid;
    t_event_kind r_out_kind, n_out_kind;
    logic        r_out_match, n_out_match;
    logic [7:0]  r_out_status, n_out_status;
    logic [4:0]  r_out_reports, n_out_reports;
    logic [31:0] r_report_total, n_report_total;
    logic [31:0] r_disabled_total, n_disabled_total;
    logic [31:0] r_malformed_total, n_malformed_total;
    logic [31:0] r_failure_total, n_failure_total;
    logic [31:0] r_dropped_total, n_dropped_total;

    // apb register access
    assign pready    = 1'b1;
    assign w_reg_hit = paddr[APB_ADDR_W-1:2] == REG_AWAITED_OPCODE;
    assign prdata    = w_reg_hit ? APB_DATA_W'(r_awaited_opcode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaited_opcode <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_awaited_opcode <= pwdata[15:0];
        end
    end

    // input register; a closing byte moves on only when the result slot frees
    assign w_s1_fire    = r_s1_valid && (!r_s1_item.last_byte || !r_out_valid || o_event.ready);
    assign w_emit       = w_s1_fire && r_s1_item.last_byte;
    assign i_byte.ready = !r_s1_valid || w_s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_s1_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_s1_item <= i_byte.data;
        end
    end

    hepc_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_s1_fire),
        .i_packet_byte(r_s1_item.packet_byte),
        .i_last_byte  (r_s1_item.last_byte),
        .o_info       (w_info)
    );

    // packet classification and total updates
    always_comb begin
        n_out_kind        = KIND_OTHER;
        n_out_match       = 1'b0;
        n_out_status      = '0;
        n_out_reports     = '0;
        n_report_total    = r_report_total;
        n_disabled_total  = r_disabled_total;
        n_malformed_total = r_malformed_total;
        n_failure_total   = r_failure_total;
        n_dropped_total   = r_dropped_total;

        if (w_info.oversize) begin
            n_out_kind      = KIND_DROPPED;
            n_dropped_total = r_dropped_total + 32'd1;
        end else if (w_info.too_short || !w_info.lead_ok || !w_info.length_ok) begin
            n_out_kind        = KIND_MALFORMED;
            n_malformed_total = r_malformed_total + 32'd1;
        end else if (w_info.evt_code == CODE_CMD_COMPLETE && w_info.at_least_7) begin
            n_out_kind   = KIND_CMD_DONE;
            n_out_status = w_info.status;
            n_out_match  = w_info.completed_opcode == r_awaited_opcode;
            if (w_info.status != '0) begin
                n_failure_total = r_failure_total + 32'd1;
            end
        end else if (w_info.evt_code == CODE_LE_META && w_info.at_least_5 &&
                     w_info.subevent == SUB_ADV_REPORT) begin
            n_out_reports  = (w_info.reports_done > 8'(REPORTS_SAT))
                           ? REPORTS_SAT : w_info.reports_done[4:0];
            n_report_total = r_report_total + 32'(w_info.reports_done);
            if (r_s1_item.scan_disabled) begin
                n_disabled_total = r_disabled_total + 32'(w_info.reports_done);
            end
            // a truncated report run is malformed after committing what completed
            if (w_info.reports_done < w_info.num_reports) begin
                n_out_kind        = KIND_MALFORMED;
                n_malformed_total = r_malformed_total + 32'd1;
            end else begin
                n_out_kind = KIND_ADV;
            end
        end
    end

    // result register and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_report_total    <= '0;
            r_disabled_total  <= '0;
            r_malformed_total <= '0;
            r_failure_total   <= '0;
            r_dropped_total   <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_report_total    <= n_report_total;
                r_disabled_total  <= n_disabled_total;
                r_malformed_total <= n_malformed_total;
                r_failure_total   <= n_failure_total;
                r_dropped_total   <= n_dropped_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind    <= n_out_kind;
            r_out_match   <= n_out_match;
            r_out_status  <= n_out_status;
            r_out_reports <= n_out_reports;
        end
    end

    // totals only move when a new result is loaded, so they drive the port directly
    assign o_event.valid                      = r_out_valid;
    assign o_event.data.event_kind            = r_out_kind;
    assign o_event.data.completion_match      = r_out_match;
    assign o_event.data.command_status        = r_out_status;
    assign o_event.data.reports_in_packet     = r_out_reports;
    assign o_event.data.report_total          = r_report_total;
    assign o_event.data.report_disabled_total = r_disabled_total;
    assign o_event.data.malformed_total       = r_malformed_total;
    assign o_event.data.failure_total         = r_failure_total;
    assign o_event.data.dropped_total         = r_dropped_total;

endmodule

[rtl/core/hepc_checker.sv]
// hepc_checker: port-level assertions for hci_event_packet_checker
// depends on hepc_pkg; attached to the top level by the bind below
module hepc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hepc_pkg::t_out_item i_out_data
);
    import hepc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // opcode match and status only accompany a command complete
    a_cmd_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.event_kind != KIND_CMD_DONE |->
            !i_out_data.completion_match && i_out_data.command_status == '0)
        else $error("command fields set on another kind");

    // committed reports only with advertising or malformed results
    a_reports_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.reports_in_packet != '0 |->
            i_out_data.event_kind == KIND_ADV || i_out_data.event_kind == KIND_MALFORMED)
        else $error("reports on wrong kind");

    // totals only change together with a fresh result
    a_totals_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid |->
            $stable(i_out_data.report_total) && $stable(i_out_data.malformed_total) &&
            $stable(i_out_data.failure_total) && $stable(i_out_data.dropped_total) &&
            $stable(i_out_data.report_disabled_total))
        else $error("totals moved without a result");

    // a fresh drop result after a gap counts exactly one drop
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_out_valid && !$past(i_out_valid) &&
        i_out_data.event_kind == KIND_DROPPED |->
            i_out_data.dropped_total == $past(i_out_data.dropped_total) + 32'd1)
        else $error("drop total not incremented");

endmodule

bind hci_event_packet_checker hepc_checker u_hepc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_event.valid),
    .i_out_ready(o_event.ready),
    .i_out_data (o_event.data)
);

[test/tb_top.sv]
// tb_top: self-checking bench for the h4 event packet checker, directed packets then random ones
// depends on hepc_pkg, hepc_stream_if and hci_event_packet_checker
// a byte-level classifier in the bench predicts every result; the monitor compares field by field
`timescale 1ns / 100ps

module tb_top;
    import hepc_pkg::*;

    localparam int unsigned MAX_BYTES     = MAX_PACKET_BYTES_DEF;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RANDOM_BYTES  = 240;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned TIMEOUT_NS    = 5_000_000;
    localparam logic [APB_ADDR_W-1:0] AWAITED_ADDR = {REG_AWAITED_OPCODE, 2'b00};

    // one directed packet: header bytes right-aligned in head, zero filler after them
    typedef struct {
        int unsigned  len;
        int unsigned  nhead;
        logic [127:0] head;
        bit           scan_off;
        bit           pinned;
        t_event_kind  kind;
        bit           match;
        logic [7:0]   status;
        logic [4:0]   reps;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    hepc_stream_if #(.t_data(t_in_item))  byte_if ();
    hepc_stream_if #(.t_data(t_out_item)) event_if ();

    hci_event_packet_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_event (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // classifier state: packet offsets, register copy, running totals
    logic [8:0]  pos;
    bit          lead_good;
    logic [7:0]  ev_code;
    logic [7:0]  par_len;
    logic [7:0]  sub_code;
    logic [15:0] cc_opcode;
    logic [7:0]  cc_status;
    logic [7:0]  rep_count;
    logic [8:0]  rep_start;
    logic [9:0]  rep_end;
    logic [7:0]  rep_done;
    logic [15:0] awaited = '0;
    logic [31:0] report_tot = '0;
    logic [31:0] disabled_tot = '0;
    logic [31:0] malformed_tot = '0;
    logic [31:0] failure_tot = '0;
    logic [31:0] dropped_tot = '0;

    t_out_item   event_q[$];
    logic [7:0]  pkt_bytes[$];
    t_dir_row    directed[$];
    int unsigned errors = 0;
    int unsigned sent_bytes = 0;
    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;
    bit          hold_req = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void clear_packet();
        pos = '0;
        lead_good = 1'b0;
        ev_code = '0;
        par_len = '0;
        sub_code = '0;
        cc_opcode = '0;
        cc_status = '0;
        rep_count = '0;
        rep_start = 9'(REPORT_START_INIT);
        rep_end = '0;
        rep_done = '0;
    endfunction

    // advances the packet state by one accepted byte; returns 1 with res filled on a last byte
    function automatic bit classify_byte(input t_in_item it, output t_out_item res);
        int unsigned p;
        int unsigned len;
        int unsigned done_cnt;
        logic [7:0]  b;
        b = it.packet_byte;
        p = pos;
        res = '0;
        // bytes past the size limit are not examined
        if (p < MAX_BYTES) begin
            case (p)
                0: lead_good = (b == LEAD_EVENT);
                1: ev_code = b;
                2: par_len = b;
                3: sub_code = b;
                4: begin
                    cc_opcode = {8'h00, b};
                    rep_count = b;
                end
                5: cc_opcode[15:8] = b;
                6: cc_status = b;
                default: ;
            endcase
            // walk advertising reports by their data length
            if (p >= 5 && rep_done < rep_count) begin
                if (rep_end == 0 && p == rep_start + REPORT_LEN_OFFSET) begin
                    rep_end = 10'(rep_start + REPORT_HDR_BYTES + b);
                end else if (rep_end != 0 && p + 1 == rep_end) begin
                    rep_done++;
                    rep_start = 9'(rep_end);
                    rep_end = '0;
                end
            end
        end
        len = p + 1;
        pos = (p > MAX_BYTES) ? 9'(p) : 9'(len);
        if (!it.last_byte)
            return 1'b0;

        // classification at the last byte
        if (len > MAX_BYTES) begin
            res.event_kind = KIND_DROPPED;
            dropped_tot++;
        end else if (len < 3 || !lead_good || len != par_len + 3) begin
            res.event_kind = KIND_MALFORMED;
            malformed_tot++;
        end else if (ev_code == CODE_CMD_COMPLETE && len >= 7) begin
            res.event_kind = KIND_CMD_DONE;
            res.command_status = cc_status;
            res.completion_match = (cc_opcode == awaited);
            if (cc_status != 0)
                failure_tot++;
        end else if (ev_code == CODE_LE_META && len >= 5 && sub_code == SUB_ADV_REPORT) begin
            done_cnt = rep_done;
            report_tot += done_cnt;
            if (it.scan_disabled)
                disabled_tot += done_cnt;
            if (rep_done < rep_count) begin
                res.event_kind = KIND_MALFORMED;
                malformed_tot++;
            end else begin
                res.event_kind = KIND_ADV;
            end
            res.reports_in_packet = (done_cnt > 31) ? REPORTS_SAT : 5'(done_cnt);
        end else begin
            res.event_kind = KIND_OTHER;
        end
        res.report_total = report_tot;
        res.report_disabled_total = disabled_tot;
        res.malformed_total = malformed_tot;
        res.failure_total = failure_tot;
        res.dropped_total = dropped_tot;
        clear_packet();
        return 1'b1;
    endfunction

    function automatic t_dir_row dir_row(input int unsigned len, input int unsigned nhead,
                                         input logic [127:0] head, input bit scan_off,
                                         input bit pinned, input t_event_kind kind,
                                         input bit match, input logic [7:0] status,
                                         input logic [4:0] reps);
        t_dir_row r;
        r.len = len;
        r.nhead = nhead;
        r.head = head;
        r.scan_off = scan_off;
        r.pinned = pinned;
        r.kind = kind;
        r.match = match;
        r.status = status;
        r.reps = reps;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // offers one byte after a random gap, none in steady mode, and waits for its transfer
    task automatic offer_byte(input t_in_item it);
        int unsigned gap;
        gap = send_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data <= it;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    // sends pkt_bytes as one packet; pinned rows take kind, match, status and reports from pin
    task automatic send_packet(input bit pinned, input t_out_item pin, input bit scan_last);
        t_in_item  it;
        t_out_item res;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            it.packet_byte = pkt_bytes[i];
            it.last_byte = (i == pkt_bytes.size() - 1);
            it.scan_disabled = it.last_byte ? scan_last : 1'($urandom_range(0, 1));
            offer_byte(it);
            sent_bytes++;
            if (classify_byte(it, res)) begin
                if (pinned) begin
                    res.event_kind = pin.event_kind;
                    res.completion_match = pin.completion_match;
                    res.command_status = pin.command_status;
                    res.reports_in_packet = pin.reports_in_packet;
                end
                event_q.push_back(res);
            end
        end
    endtask

    // stops offering bytes and waits until every classification has come out
    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the awaited opcode, then read back
    task automatic write_awaited(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AWAITED_ADDR;
        pwdata <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        awaited = value;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("awaited_opcode readback", {16'h0000, value}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // random packet, mostly well-formed command completes and advertising reports
    task automatic make_packet();
        int unsigned pick;
        int unsigned n;
        int unsigned dlen;
        int unsigned cut;
        logic [15:0] op;
        pkt_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // command complete with optional trailing parameters
            n = $urandom_range(0, 6);
            op = $urandom_range(0, 1) ? awaited : 16'($urandom);
            pkt_bytes = '{LEAD_EVENT, CODE_CMD_COMPLETE, 8'(4 + n), 8'($urandom), op[7:0],
                          op[15:8], ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00};
            repeat (n) pkt_bytes.push_back(8'($urandom));
        end else if (pick < 75) begin
            // advertising report run, sometimes cut short, padded or with a wrong count
            n = $urandom_range(0, 4);
            pkt_bytes = '{LEAD_EVENT, CODE_LE_META, 8'h00, SUB_ADV_REPORT, 8'(n)};
            repeat (n) begin
                dlen = $urandom_range(0, 8);
                repeat (8) pkt_bytes.push_back(8'($urandom));
                pkt_bytes.push_back(8'(dlen));
                repeat (dlen + 1) pkt_bytes.push_back(8'($urandom));
            end
            if ($urandom_range(0, 7) == 0)
                pkt_bytes[4] = 8'($urandom);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 4) == 0 && pkt_bytes.size() > 6) begin
                cut = $urandom_range(5, pkt_bytes.size() - 1);
                while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
            pkt_bytes[2] = 8'(pkt_bytes.size() - 3);
        end else if (pick < 87) begin
            // any event code with consistent length
            n = $urandom_range(0, 10);
            pkt_bytes = '{LEAD_EVENT, 8'($urandom), 8'(n)};
            repeat (n) pkt_bytes.push_back(8'($urandom));
        end else if (pick < 92) begin
            // meta event with a random subevent
            n = $urandom_range(1, 8);
            pkt_bytes = '{LEAD_EVENT, CODE_LE_META, 8'(n), 8'($urandom)};
            repeat (n - 1) pkt_bytes.push_back(8'($urandom));
        end else begin
            // noise: random bytes, lead byte right half the time
            n = $urandom_range(1, 12);
            repeat (n) pkt_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                pkt_bytes[0] = LEAD_EVENT;
        end
    endtask

    // result receiver: random stalls, steady stretches, one long hold-off on request
    initial begin
        int unsigned gap;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            gap = take_steady ? 0 : $urandom_range(0, 17);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                event_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            event_if.ready <= 1'b1;
            do @(posedge i_clk); while (!event_if.valid);
        end
    end

    // result monitor: every transfer against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && event_if.valid && event_if.ready) begin
            if (event_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         event_if.data);
                errors++;
            end else begin
                want = event_q.pop_front();
                check_field("event_kind", want.event_kind, event_if.data.event_kind);
                check_field("completion_match", want.completion_match,
                            event_if.data.completion_match);
                check_field("command_status", want.command_status,
                            event_if.data.command_status);
                check_field("reports_in_packet", want.reports_in_packet,
                            event_if.data.reports_in_packet);
                check_field("report_total", want.report_total, event_if.data.report_total);
                check_field("report_disabled_total", want.report_disabled_total,
                            event_if.data.report_disabled_total);
                check_field("malformed_total", want.malformed_total,
                            event_if.data.malformed_total);
                check_field("failure_total", want.failure_total, event_if.data.failure_total);
                check_field("dropped_total", want.dropped_total, event_if.data.dropped_total);
            end
        end
    end

    // main sequence
    initial begin
        t_out_item   pin;
        t_dir_row    row;
        logic [15:0] phase_op [4];

        byte_if.valid <= 1'b0;
        byte_if.data <= '0;
        event_if.ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        clear_packet();
        // long receiver hold-off over the first short directed packets
        hold_req = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets, awaited opcode still at its reset value of zero
        directed.push_back(dir_row(1, 1, 'h04, 0, 1, KIND_MALFORMED, 0, 8'h00, 0));
        directed.push_back(dir_row(2, 2, 'h040e, 0, 1, KIND_MALFORMED, 0, 8'h00, 0));
        directed.push_back(dir_row(3, 3, 'h041300, 0, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(7, 7, 'h050e0401000000, 0, 1, KIND_MALFORMED, 0, 8'h00, 0));
        directed.push_back(dir_row(7, 7, 'h040e0501000000, 0, 1, KIND_MALFORMED, 0, 8'h00, 0));
        directed.push_back(dir_row(7, 7, 'h040e0401000000, 0, 1, KIND_CMD_DONE, 1, 8'h00, 0));
        directed.push_back(dir_row(7, 7, 'h040e0401030c00, 0, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(7, 7, 'h040e04010000ff, 0, 1, KIND_CMD_DONE, 1, 8'hff, 0));
        directed.push_back(dir_row(7, 7, 'h040e04ffffff01, 1, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(10, 7, 'h040e0701000000, 0, 0, KIND_OTHER, 0, 8'h00, 0));
        // short command complete is an ordinary event
        directed.push_back(dir_row(6, 6, 'h040e03010000, 0, 1, KIND_OTHER, 0, 8'h00, 0));
        // zero report count
        directed.push_back(dir_row(5, 5, 'h043e020200, 0, 1, KIND_ADV, 0, 8'h00, 0));
        directed.push_back(dir_row(15, 5, 'h043e0c0201, 1, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(17, 14, 'h043e0e02010000000000000000_02, 1, 0, KIND_OTHER,
                                   0, 8'h00, 0));
        // truncated run: one of two reports complete
        directed.push_back(dir_row(15, 5, 'h043e0c0202, 1, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(5, 5, 'h043e020100, 0, 0, KIND_OTHER, 0, 8'h00, 0));
        // most reports that fit in a packet
        directed.push_back(dir_row(255, 5, 'h043efc0219, 1, 0, KIND_OTHER, 0, 8'h00, 0));
        // longest well-formed packet, then sizes around the limit
        directed.push_back(dir_row(258, 3, 'h0405ff, 0, 0, KIND_OTHER, 0, 8'h00, 0));
        directed.push_back(dir_row(MAX_BYTES, 3, 'h0405ff, 0, 1, KIND_MALFORMED, 0, 8'h00, 0));
        directed.push_back(dir_row(MAX_BYTES + 1, 1, 'h04, 0, 1, KIND_DROPPED, 0, 8'h00, 0));
        directed.push_back(dir_row(MAX_BYTES + 2, 1, 'h04, 1, 1, KIND_DROPPED, 0, 8'h00, 0));
        directed.push_back(dir_row(1, 1, 'hff, 1, 1, KIND_MALFORMED, 0, 8'h00, 0));

        foreach (directed[k]) begin
            row = directed[k];
            pkt_bytes.delete();
            for (int i = 0; i < row.len; i++)
                pkt_bytes.push_back((i < row.nhead) ? row.head[8*(row.nhead-1-i) +: 8] : 8'h00);
            pin = '0;
            pin.event_kind = row.kind;
            pin.completion_match = row.match;
            pin.command_status = row.status;
            pin.reports_in_packet = row.reps;
            if ($urandom_range(0, 3) == 0)
                send_steady = !send_steady;
            send_packet(row.pinned, pin, row.scan_off);
        end

        // random phases, each under its own awaited opcode
        phase_op = '{16'hffff, 16'($urandom), 16'h0000, 16'($urandom)};
        sent_bytes = 0;
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_awaited(phase_op[ph]);
            while (sent_bytes < (ph + 1) * RANDOM_BYTES / 4) begin
                if ($urandom_range(0, 7) == 0)
                    send_steady = !send_steady;
                make_packet();
                send_packet(1'b0, '0, 1'($urandom_range(0, 1)));
            end
        end

        wait_idle();
        if (errors == 0 && event_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
